@@ hdl/keyed_sector_longword_codec_macros.svh @@
// Assertion macros shared by the codec modules.
`ifndef KEYED_SECTOR_LONGWORD_CODEC_MACROS_SVH
`define KEYED_SECTOR_LONGWORD_CODEC_MACROS_SVH

`ifndef SYNTHESIS

`define KSLC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define KSLC_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`define KSLC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define KSLC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)

`define KSLC_ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)

`define KSLC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

@@ hdl/kslc_pkg.sv @@
package kslc_pkg;

   localparam int LONGS_W = 13;
   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] KEY_START = 32'heff478ed;
   localparam logic [WORD_W-1:0] KEY_STEP = 32'hbffb7e5e;

   localparam logic [LONGS_W-1:0] MAX_LONGS_RESET = 13'd1536;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_BODY = 1'b1;

   localparam logic [1:0] ITEM_HEADER = 2'd0;
   localparam logic [1:0] ITEM_DATA = 2'd1;
   localparam logic [1:0] ITEM_CSUM = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_COUNT = 2'd2;

   localparam logic REG_DIRECTION = 1'b0;
   localparam logic REG_MAX_LONGS = 1'b1;

   localparam int RSP_FIFO_DEPTH = 4;

   typedef struct packed {
      logic [1:0] item_type;
      logic [WORD_W-1:0] value;
      logic [1:0] status;
      logic last;
   } result_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

@@ hdl/kslc_channels.sv @@
interface kslc_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic [kslc_pkg::WORD_W-1:0] word;

   modport source (output valid, output kind, output word, input ready);
   modport sink (input valid, input kind, input word, output ready);
endinterface

interface kslc_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] item_type;
   logic [kslc_pkg::WORD_W-1:0] value;
   logic [1:0] status;
   logic last;

   modport source (output valid, output item_type, output value, output status,
                   output last, input ready);
   modport sink (input valid, input item_type, input value, input status,
                 input last, output ready);
endinterface

@@ hdl/kslc_rsp_fifo.sv @@
`include "keyed_sector_longword_codec_macros.svh"

module kslc_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  kslc_pkg::push_type    push,
   input  kslc_pkg::result_type  res_first,
   input  kslc_pkg::result_type  res_second,
   output logic                  room,
   kslc_rsp_if.source            rsp_chan
);

   localparam int DEPTH = kslc_pkg::RSP_FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   kslc_pkg::result_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic pop;

   assign pop = rsp_chan.valid & rsp_chan.ready;
   assign room = count_ff <= CNT_W'(DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.first) + PTR_W'(push.second);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entries_ff[wr_ptr_ff] <= res_first;
      end
      if (push.second) begin
         entries_ff[wr_ptr_next] <= res_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign rsp_chan.valid = count_ff != '0;
   assign rsp_chan.item_type = entries_ff[rd_ptr_ff].item_type;
   assign rsp_chan.value = entries_ff[rd_ptr_ff].value;
   assign rsp_chan.status = entries_ff[rd_ptr_ff].status;
   assign rsp_chan.last = entries_ff[rd_ptr_ff].last;

   `KSLC_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "result queue count beyond depth")
   `KSLC_ASSERT_IMPLY(a_push_order, clock, reset, push.second, push.first, "second result pushed without first")
   `KSLC_ASSERT_IMPLY(a_push_room, clock, reset, push.first, room, "result pushed without room for two")

endmodule

@@ hdl/keyed_sector_longword_codec.sv @@
// Keyed sector longword codec: takes one longword beat per clock cycle on req_chan and
// answers with one result beat per sector header, per data word and per checksum word; in
// encode mode the final data word of a sector yields two beats (data word, then checksum).
// All keying and summing for a beat is done in the cycle it is accepted. Results pass
// through a four-entry queue and leave at one beat per cycle while the receiver is ready;
// req_chan.ready is high whenever the queue has room for two results. The input therefore
// stalls only when the receiver holds off or when two-result beats arrive faster than the
// queue drains. A beat's results are registered in the queue before they reach rsp_chan.
`include "keyed_sector_longword_codec_macros.svh"

module keyed_sector_longword_codec #(
   parameter int MAX_SECTOR_LONGS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   kslc_req_if.sink                       req_chan,
   kslc_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [kslc_pkg::LONGS_W-1:0]   csr_data
);

   localparam int LW = kslc_pkg::LONGS_W;
   localparam int WW = kslc_pkg::WORD_W;
   localparam int CMP_W = 17;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_CSUM = 2'd2;

   logic direction_ff, direction_in;
   logic [LW-1:0] max_longs_ff, max_longs_in;
   logic [1:0] phase_ff, phase_in;
   logic [WW-1:0] key_ff, key_in;
   logic [WW-1:0] neg_sum_ff, neg_sum_in;
   logic [LW-1:0] remaining_ff, remaining_in;

   logic accept;
   logic room;
   logic enc;
   logic [LW-1:0] limit;
   logic [15:0] hdr_count;
   logic hdr_over;
   logic [LW-1:0] hdr_longs;
   logic [WW-1:0] hdr_plain;
   logic [WW-1:0] data_plain;
   logic [WW-1:0] data_neg_sum;

   kslc_pkg::push_type push;
   kslc_pkg::result_type res_first, res_second;

   assign accept = req_chan.valid & req_chan.ready;
   assign req_chan.ready = room;
   assign enc = direction_ff;

   always_comb begin
      if ({4'b0, max_longs_ff} > CMP_W'(MAX_SECTOR_LONGS)) begin
         limit = LW'(MAX_SECTOR_LONGS);
      end else begin
         limit = max_longs_ff;
      end
   end

   assign hdr_plain = enc ? req_chan.word : ~req_chan.word;
   assign hdr_count = hdr_plain[15:0];
   assign hdr_over = (hdr_count != '0) && (hdr_count > 16'(limit));
   assign hdr_longs = (hdr_count == '0) ? limit : hdr_count[LW-1:0];

   assign data_plain = enc ? req_chan.word : req_chan.word - key_ff;
   assign data_neg_sum = neg_sum_ff - data_plain;

   always_comb begin
      direction_in = direction_ff;
      max_longs_in = max_longs_ff;
      phase_in = phase_ff;
      key_in = key_ff;
      neg_sum_in = neg_sum_ff;
      remaining_in = remaining_ff;
      push = '0;
      res_first = '0;
      res_second = '0;

      if (accept) begin
         if (req_chan.kind == kslc_pkg::KIND_HEADER) begin
            push.first = 1'b1;
            res_first.item_type = kslc_pkg::ITEM_HEADER;
            res_first.value = ~req_chan.word;
            if (hdr_over) begin
               res_first.status = kslc_pkg::STATUS_COUNT;
               res_first.last = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               res_first.status = kslc_pkg::STATUS_OK;
               key_in = kslc_pkg::KEY_START;
               neg_sum_in = -hdr_plain;
               remaining_in = hdr_longs;
               if (hdr_longs != '0) begin
                  phase_in = PH_DATA;
               end else if (enc) begin
                  phase_in = PH_IDLE;
                  push.second = 1'b1;
                  res_second.item_type = kslc_pkg::ITEM_CSUM;
                  res_second.value = -hdr_plain;
                  res_second.status = kslc_pkg::STATUS_OK;
                  res_second.last = 1'b1;
               end else begin
                  phase_in = PH_CSUM;
               end
            end
         end else if (phase_ff == PH_DATA) begin
            push.first = 1'b1;
            res_first.item_type = kslc_pkg::ITEM_DATA;
            res_first.value = enc ? req_chan.word + key_ff : data_plain;
            res_first.status = kslc_pkg::STATUS_OK;
            key_in = key_ff + kslc_pkg::KEY_STEP;
            neg_sum_in = data_neg_sum;
            remaining_in = remaining_ff - LW'(1);
            if (remaining_ff == LW'(1)) begin
               if (enc) begin
                  phase_in = PH_IDLE;
                  push.second = 1'b1;
                  res_second.item_type = kslc_pkg::ITEM_CSUM;
                  res_second.value = data_neg_sum;
                  res_second.status = kslc_pkg::STATUS_OK;
                  res_second.last = 1'b1;
               end else begin
                  phase_in = PH_CSUM;
               end
            end
         end else if (phase_ff == PH_CSUM && !enc) begin
            push.first = 1'b1;
            res_first.item_type = kslc_pkg::ITEM_CSUM;
            res_first.value = req_chan.word;
            res_first.status = (req_chan.word != neg_sum_ff) ?
                               kslc_pkg::STATUS_MISMATCH : kslc_pkg::STATUS_OK;
            res_first.last = 1'b1;
            phase_in = PH_IDLE;
         end
      end

      if (csr_we) begin
         phase_in = PH_IDLE;
         case (csr_index)
            kslc_pkg::REG_DIRECTION: direction_in = csr_data[0];
            kslc_pkg::REG_MAX_LONGS: max_longs_in = csr_data;
            default: direction_in = direction_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         max_longs_ff <= kslc_pkg::MAX_LONGS_RESET;
         phase_ff <= PH_IDLE;
         key_ff <= kslc_pkg::KEY_START;
         neg_sum_ff <= '0;
         remaining_ff <= '0;
      end else begin
         direction_ff <= direction_in;
         max_longs_ff <= max_longs_in;
         phase_ff <= phase_in;
         key_ff <= key_in;
         neg_sum_ff <= neg_sum_in;
         remaining_ff <= remaining_in;
      end
   end

   kslc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .res_first  (res_first),
      .res_second (res_second),
      .room       (room),
      .rsp_chan   (rsp_chan)
   );

   `KSLC_ASSERT_IMPLY(a_data_remaining, clock, reset, phase_ff == PH_DATA, remaining_ff != '0, "data phase with no words remaining")
   `KSLC_ASSERT_IMPLY(a_csum_decode_only, clock, reset, phase_ff == PH_CSUM && !csr_we && !$past(csr_we), !enc, "checksum wait phase while encoding")
   `KSLC_ASSERT_NEXT(a_header_key, clock, reset, accept && !csr_we && req_chan.kind == kslc_pkg::KIND_HEADER && !hdr_over, key_ff == kslc_pkg::KEY_START && remaining_ff == $past(hdr_longs), "key not restarted by header")

endmodule
